// ----- rtl/rd12_pkg.sv -----
package rd12_pkg;

    localparam int IN_WIDTH_DEF       = 16;
    localparam int OUT_WIDTH_DEF      = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // headroom for the twelve-term sums and the sqrt(3) products
    localparam int GROWTH_BITS = 5;
    localparam int N_POINTS    = 12;

    // sqrt(3)/2 in Q32, rounded
    localparam logic [63:0] SQ3H_Q32 = 64'd3719550787;

    localparam int SCALE_SQ3H = 1;
    localparam int SCALE_SQ3  = 2;

    // sqrt(3)/2 (scale_log2 = 1) or sqrt(3) (scale_log2 = 2) with frac_bits fraction bits
    function automatic logic [63:0] sq3_coef(input int frac_bits, input int scale_log2);
        logic [63:0] t;
        t = SQ3H_Q32 >> (32 - frac_bits - scale_log2);
        return (t + 64'd1) >> 1;
    endfunction

endpackage

// ----- rtl/rd12_cmul.sv -----
module rd12_cmul #(
    parameter int W          = 21,
    parameter int F          = rd12_pkg::COEF_FRAC_BITS_DEF,
    parameter int SCALE_LOG2 = rd12_pkg::SCALE_SQ3H
) (
    input  logic signed [W-1:0] x,
    output logic signed [W-1:0] y
);

    localparam int KW = F + 3;
    localparam int PW = W + KW;
    localparam logic signed [KW-1:0] K   = KW'(rd12_pkg::sq3_coef(F, SCALE_LOG2));
    localparam logic signed [PW-1:0] RND = PW'(1) << (F - 1);

    logic signed [PW-1:0] prod;

    assign prod = PW'(x) * PW'(K) + RND;
    assign y    = W'(prod >>> F);

endmodule

// ----- rtl/rd12_fwd.sv -----
module rd12_fwd #(
    parameter int W = 21,
    parameter int F = rd12_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic signed [W-1:0] v [rd12_pkg::N_POINTS],
    output logic signed [W-1:0] r [rd12_pkg::N_POINTS]
);

    logic signed [W-1:0] a0, a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11;
    logic signed [W-1:0] a12, a13, a14, a15, a16, a17, a18, a19, a20, a21;
    logic signed [W-1:0] a24, a25, a26, a27, a28, a29, a30, a33, p28, p29;

    assign a0  = v[11] + v[1];
    assign a1  = v[11] - v[1];
    assign a2  = v[5] + v[7];
    assign a3  = v[5] - v[7];
    assign a4  = v[0] + v[6];
    assign a5  = v[0] - v[6];
    assign a6  = v[10] + v[2];
    assign a7  = v[10] - v[2];
    assign a8  = v[4] + v[8];
    assign a9  = v[4] - v[8];
    assign a10 = v[9] + v[3];
    assign a11 = v[9] - v[3];
    assign a12 = a0 + a2;
    assign a13 = a0 - a2;
    assign a14 = a6 + a8;
    assign a15 = a6 - a8;
    assign a16 = a1 + a3;
    assign a17 = a1 - a3;
    assign a18 = a4 + a10;
    assign a19 = a4 - a10;
    assign a20 = a12 + a14;
    assign a21 = a12 - a14;
    assign a24 = a5 + (a15 >>> 1);
    assign a25 = (a17 >>> 1) + a11;
    assign a26 = a7 + a9;
    assign a27 = a7 - a9;
    assign a28 = a16 + a26;
    assign a29 = a16 - a26;

    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3H)) u_m30 (.x(a13), .y(a30));
    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3H)) u_m33 (.x(a27), .y(a33));
    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3H)) u_m28 (.x(a28), .y(p28));
    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3H)) u_m29 (.x(a29), .y(p29));

    assign r[0]  = a20 + a18;
    assign r[1]  = a24 + a30;
    assign r[2]  = a25 + a33;
    assign r[3]  = (a21 >>> 1) + a19;
    assign r[4]  = p28;
    assign r[5]  = a5 - a15;
    assign r[6]  = a17 - a11;
    assign r[7]  = a18 - (a20 >>> 1);
    assign r[8]  = p29;
    assign r[9]  = a24 - a30;
    assign r[10] = a25 - a33;
    assign r[11] = a19 - a21;

endmodule

// ----- rtl/rd12_bwd.sv -----
module rd12_bwd #(
    parameter int W = 21,
    parameter int F = rd12_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic signed [W-1:0] v [rd12_pkg::N_POINTS],
    output logic signed [W-1:0] r [rd12_pkg::N_POINTS]
);

    logic signed [W-1:0] a0, a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11;
    logic signed [W-1:0] a12, a13, a14, a15, a18, a19, a22, a23, a24, a25, a26;
    logic signed [W-1:0] a30, a31, a32, a33, a34, a35;
    logic signed [W-1:0] s36, d36, s97, d97;

    assign a0  = v[0] + v[11];
    assign a1  = v[0] - v[11];
    assign a2  = v[1] + v[9];
    assign a3  = v[1] - v[9];
    assign a4  = v[3] + v[7];
    assign a5  = v[3] - v[7];
    assign a6  = v[4] + v[8];
    assign a7  = v[4] - v[8];
    assign a8  = v[10] + v[2];
    assign a9  = v[10] - v[2];
    assign a10 = v[5] <<< 1;
    assign a11 = v[6] <<< 1;
    assign a12 = a2 + a4;
    assign a13 = a0 + a10;
    assign a14 = a0 - a10;
    assign a15 = a12 <<< 1;
    assign s36 = a3 + a6;
    assign d36 = a3 - a6;
    assign s97 = a9 + a7;
    assign d97 = a9 - a7;

    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3)) u_m18 (.x(s36), .y(a18));
    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3)) u_m19 (.x(d36), .y(a19));
    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3)) u_m22 (.x(s97), .y(a22));
    rd12_cmul #(.W(W), .F(F), .SCALE_LOG2(rd12_pkg::SCALE_SQ3)) u_m23 (.x(d97), .y(a23));

    assign a24 = a5 + a8;
    assign a25 = a5 - a8;
    assign a26 = a2 - a4;
    assign a30 = a1 - a11;
    assign a31 = a1 + a11;
    assign a32 = a25 + a30;
    assign a33 = a31 + a24;
    assign a34 = a13 - a12;
    assign a35 = a14 + a26;

    assign r[0]  = a13 + a15;
    assign r[1]  = a19 + a32;
    assign r[2]  = a23 + a35;
    assign r[3]  = a31 - (a24 <<< 1);
    assign r[4]  = a34 + a22;
    assign r[5]  = a32 - a19;
    assign r[6]  = a14 - (a26 <<< 1);
    assign r[7]  = a33 - a18;
    assign r[8]  = a34 - a22;
    assign r[9]  = a30 - (a25 <<< 1);
    assign r[10] = a35 - a23;
    assign r[11] = a33 + a18;

endmodule

// ----- rtl/real_dft12_butterfly.sv -----
// Twelve-point real DFT of one frame per word. direction 0 gives the forward
// transform in permuted halfcomplex order, direction 1 the unnormalized inverse
// (gain 12). A frame is accepted every clock while the output is not stalled; it
// passes through the input register, then the add and sqrt(3) multiply network
// into the result register. With the output stalled, one frame waits in each
// register and in_ready drops only when both are full.
// Write direction only while no frame is in flight.
module real_dft12_butterfly #(
    parameter int IN_WIDTH       = rd12_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH      = rd12_pkg::OUT_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = rd12_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [IN_WIDTH-1:0]  sample_0,
    input  logic signed [IN_WIDTH-1:0]  sample_1,
    input  logic signed [IN_WIDTH-1:0]  sample_2,
    input  logic signed [IN_WIDTH-1:0]  sample_3,
    input  logic signed [IN_WIDTH-1:0]  sample_4,
    input  logic signed [IN_WIDTH-1:0]  sample_5,
    input  logic signed [IN_WIDTH-1:0]  sample_6,
    input  logic signed [IN_WIDTH-1:0]  sample_7,
    input  logic signed [IN_WIDTH-1:0]  sample_8,
    input  logic signed [IN_WIDTH-1:0]  sample_9,
    input  logic signed [IN_WIDTH-1:0]  sample_10,
    input  logic signed [IN_WIDTH-1:0]  sample_11,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [OUT_WIDTH-1:0] result_0,
    output logic signed [OUT_WIDTH-1:0] result_1,
    output logic signed [OUT_WIDTH-1:0] result_2,
    output logic signed [OUT_WIDTH-1:0] result_3,
    output logic signed [OUT_WIDTH-1:0] result_4,
    output logic signed [OUT_WIDTH-1:0] result_5,
    output logic signed [OUT_WIDTH-1:0] result_6,
    output logic signed [OUT_WIDTH-1:0] result_7,
    output logic signed [OUT_WIDTH-1:0] result_8,
    output logic signed [OUT_WIDTH-1:0] result_9,
    output logic signed [OUT_WIDTH-1:0] result_10,
    output logic signed [OUT_WIDTH-1:0] result_11
);

    localparam int W = IN_WIDTH + rd12_pkg::GROWTH_BITS;
    localparam int N = rd12_pkg::N_POINTS;

    logic                        direction_reg, direction_next;
    logic                        stg_valid_reg, stg_valid_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [IN_WIDTH-1:0]  sample_next [N];
    logic signed [IN_WIDTH-1:0]  sample_reg  [N];
    logic signed [W-1:0]         ext         [N];
    logic signed [W-1:0]         fwd_r       [N];
    logic signed [W-1:0]         bwd_r       [N];
    logic signed [OUT_WIDTH-1:0] result_next [N];
    logic signed [OUT_WIDTH-1:0] result_reg  [N];
    logic                        stg_advance;
    logic                        in_fire;

    assign sample_next[0]  = sample_0;
    assign sample_next[1]  = sample_1;
    assign sample_next[2]  = sample_2;
    assign sample_next[3]  = sample_3;
    assign sample_next[4]  = sample_4;
    assign sample_next[5]  = sample_5;
    assign sample_next[6]  = sample_6;
    assign sample_next[7]  = sample_7;
    assign sample_next[8]  = sample_8;
    assign sample_next[9]  = sample_9;
    assign sample_next[10] = sample_10;
    assign sample_next[11] = sample_11;

    assign stg_advance = !out_valid_reg || out_ready;
    assign in_ready    = !stg_valid_reg || stg_advance;
    assign in_fire     = in_valid && in_ready;

    always_comb
    begin
        direction_next = cfg_we ? cfg_wdata : direction_reg;
        if (in_fire)
            stg_valid_next = 1'b1;
        else if (stg_advance)
            stg_valid_next = 1'b0;
        else
            stg_valid_next = stg_valid_reg;
        out_valid_next = stg_advance ? stg_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
            ext[i] = W'(sample_reg[i]);
    end

    rd12_fwd #(.W(W), .F(COEF_FRAC_BITS)) u_fwd (.v(ext), .r(fwd_r));
    rd12_bwd #(.W(W), .F(COEF_FRAC_BITS)) u_bwd (.v(ext), .r(bwd_r));

    always_comb
    begin
        for (int i = 0; i < N; i++)
            result_next[i] = direction_reg ? OUT_WIDTH'(bwd_r[i]) : OUT_WIDTH'(fwd_r[i]);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= sample_next;
        if (stg_valid_reg && stg_advance)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result_0  = result_reg[0];
    assign result_1  = result_reg[1];
    assign result_2  = result_reg[2];
    assign result_3  = result_reg[3];
    assign result_4  = result_reg[4];
    assign result_5  = result_reg[5];
    assign result_6  = result_reg[6];
    assign result_7  = result_reg[7];
    assign result_8  = result_reg[8];
    assign result_9  = result_reg[9];
    assign result_10 = result_reg[10];
    assign result_11 = result_reg[11];

endmodule

// ----- rtl/rd12_checker.sv -----
module rd12_checker #(
    parameter int OUT_WIDTH = rd12_pkg::OUT_WIDTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [OUT_WIDTH-1:0] result_0,
    input logic signed [OUT_WIDTH-1:0] result_1,
    input logic signed [OUT_WIDTH-1:0] result_2,
    input logic signed [OUT_WIDTH-1:0] result_3,
    input logic signed [OUT_WIDTH-1:0] result_4,
    input logic signed [OUT_WIDTH-1:0] result_5,
    input logic signed [OUT_WIDTH-1:0] result_6,
    input logic signed [OUT_WIDTH-1:0] result_7,
    input logic signed [OUT_WIDTH-1:0] result_8,
    input logic signed [OUT_WIDTH-1:0] result_9,
    input logic signed [OUT_WIDTH-1:0] result_10,
    input logic signed [OUT_WIDTH-1:0] result_11
);

    // a stalled word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the word was taken");

    // a stalled word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(result_0) && $stable(result_1) && $stable(result_2) &&
            $stable(result_3) && $stable(result_4) && $stable(result_5) &&
            $stable(result_6) && $stable(result_7) && $stable(result_8) &&
            $stable(result_9) && $stable(result_10) && $stable(result_11))
        else $error("result changed while stalled");

    // input side never stalls while the output drains
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready || !out_valid |-> in_ready)
        else $error("in_ready low with the output free");

    // a new output word follows an accepted input through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("out_valid rose without a matching input word");

endmodule

bind real_dft12_butterfly rd12_checker #(.OUT_WIDTH(OUT_WIDTH)) u_rd12_checker (.*);

// ----- verif/real_dft12_butterfly_test.sv -----
`timescale 1ns / 100ps

module real_dft12_butterfly_test;

    localparam int IN_W     = rd12_pkg::IN_WIDTH_DEF;
    localparam int OUT_W    = rd12_pkg::OUT_WIDTH_DEF;
    localparam int N_POINTS = rd12_pkg::N_POINTS;

    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    localparam longint SQ3_HALF_Q16 = 56756;
    localparam longint SQ3_Q16      = 113512;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_PRINTS    = 40;

    typedef logic [N_POINTS-1:0][IN_W-1:0]  frame_t;
    typedef logic [N_POINTS-1:0][OUT_W-1:0] spectrum_t;

    typedef struct {
        logic      dir;
        frame_t    frame;
        logic      typed;
        spectrum_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      in_valid;
    logic      in_ready;
    frame_t    frame_q;
    logic      out_valid;
    logic      out_ready = 1'b0;
    logic signed [OUT_W-1:0] result_0, result_1, result_2, result_3, result_4, result_5;
    logic signed [OUT_W-1:0] result_6, result_7, result_8, result_9, result_10, result_11;

    spectrum_t pending_spectra[$];
    stim_row_t stim_rows[$];
    spectrum_t got_spectrum;
    spectrum_t want_spectrum;

    logic model_dir;
    logic rx_hold;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   error_count  = 0;
    int   results_seen = 0;
    int   frames_fwd;
    int   frames_bwd;
    int   input_stalls = 0;
    int   cycle_count  = 0;

    real_dft12_butterfly u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_0  (frame_q[0]),
        .sample_1  (frame_q[1]),
        .sample_2  (frame_q[2]),
        .sample_3  (frame_q[3]),
        .sample_4  (frame_q[4]),
        .sample_5  (frame_q[5]),
        .sample_6  (frame_q[6]),
        .sample_7  (frame_q[7]),
        .sample_8  (frame_q[8]),
        .sample_9  (frame_q[9]),
        .sample_10 (frame_q[10]),
        .sample_11 (frame_q[11]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_0  (result_0),
        .result_1  (result_1),
        .result_2  (result_2),
        .result_3  (result_3),
        .result_4  (result_4),
        .result_5  (result_5),
        .result_6  (result_6),
        .result_7  (result_7),
        .result_8  (result_8),
        .result_9  (result_9),
        .result_10 (result_10),
        .result_11 (result_11)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint halve(input longint x);
        return x >>> 1;
    endfunction

    function automatic longint coef_mul(input longint x, input longint k);
        return (x * k + 64'sd32768) >>> rd12_pkg::COEF_FRAC_BITS_DEF;
    endfunction

    // 12-point real DFT (forward) or its unnormalized inverse (backward)
    function automatic spectrum_t predict_spectrum(input frame_t f, input logic dir);
        longint v[N_POINTS];
        longint r[N_POINTS];
        longint e0, e1, e2, e3, e4, e5, o0, o1, o2, o3, o4, o5, d5, d6;
        longint t_a, t_b, t_c, t_d, t_e, t_f, t_g, t_h, t_i, t_j, t_k, t_l, t_m, t_n;
        longint m0, m1, c0, c1, c2, c3;
        spectrum_t s;
        for (int i = 0; i < N_POINTS; i++)
            v[i] = longint'($signed(f[i]));
        if (dir == DIR_FORWARD)
        begin
            e0 = v[11] + v[1];  o0 = v[11] - v[1];
            e1 = v[5] + v[7];   o1 = v[5] - v[7];
            e2 = v[0] + v[6];   o2 = v[0] - v[6];
            e3 = v[10] + v[2];  o3 = v[10] - v[2];
            e4 = v[4] + v[8];   o4 = v[4] - v[8];
            e5 = v[9] + v[3];   o5 = v[9] - v[3];
            t_a = e0 + e1;  t_b = e0 - e1;
            t_c = e3 + e4;  t_d = e3 - e4;
            t_e = o0 + o1;  t_f = o0 - o1;
            t_g = e2 + e5;  t_h = e2 - e5;
            t_i = t_a + t_c;  t_j = t_a - t_c;
            m0 = o2 + halve(t_d);
            m1 = halve(t_f) + o5;
            t_k = o3 + o4;  t_l = o3 - o4;
            t_m = t_e + t_k;  t_n = t_e - t_k;
            c0 = coef_mul(t_b, SQ3_HALF_Q16);
            c1 = coef_mul(t_l, SQ3_HALF_Q16);
            r[0]  = t_i + t_g;
            r[1]  = m0 + c0;
            r[2]  = m1 + c1;
            r[3]  = halve(t_j) + t_h;
            r[4]  = coef_mul(t_m, SQ3_HALF_Q16);
            r[5]  = o2 - t_d;
            r[6]  = t_f - o5;
            r[7]  = t_g - halve(t_i);
            r[8]  = coef_mul(t_n, SQ3_HALF_Q16);
            r[9]  = m0 - c0;
            r[10] = m1 - c1;
            r[11] = t_h - t_j;
        end
        else
        begin
            e0 = v[0] + v[11];  o0 = v[0] - v[11];
            e1 = v[1] + v[9];   o1 = v[1] - v[9];
            e2 = v[3] + v[7];   o2 = v[3] - v[7];
            e3 = v[4] + v[8];   o3 = v[4] - v[8];
            e4 = v[10] + v[2];  o4 = v[10] - v[2];
            d5 = v[5] * 2;
            d6 = v[6] * 2;
            t_a = e1 + e2;
            t_b = e0 + d5;  t_c = e0 - d5;
            t_d = t_a * 2;
            c0 = coef_mul(o1 + e3, SQ3_Q16);
            c1 = coef_mul(o1 - e3, SQ3_Q16);
            c2 = coef_mul(o4 + o3, SQ3_Q16);
            c3 = coef_mul(o4 - o3, SQ3_Q16);
            t_e = o2 + e4;  t_f = o2 - e4;
            t_g = e1 - e2;
            t_h = o0 - d6;  t_i = o0 + d6;
            t_j = t_f + t_h;  t_k = t_i + t_e;
            t_l = t_b - t_a;  t_m = t_c + t_g;
            r[0]  = t_b + t_d;
            r[1]  = c1 + t_j;
            r[2]  = c3 + t_m;
            r[3]  = t_i - t_e * 2;
            r[4]  = t_l + c2;
            r[5]  = t_j - c1;
            r[6]  = t_c - t_g * 2;
            r[7]  = t_k - c0;
            r[8]  = t_l - c2;
            r[9]  = t_h - t_f * 2;
            r[10] = t_m - c3;
            r[11] = t_k + c0;
        end
        for (int i = 0; i < N_POINTS; i++)
            s[i] = OUT_W'(r[i]);
        return s;
    endfunction

    function automatic frame_t fill_frame(input logic [IN_W-1:0] x);
        frame_t f;
        for (int i = 0; i < N_POINTS; i++)
            f[i] = x;
        return f;
    endfunction

    function automatic frame_t alt_frame(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
        frame_t f;
        for (int i = 0; i < N_POINTS; i++)
            f[i] = i[0] ? b : a;
        return f;
    endfunction

    function automatic frame_t one_hot(input int idx, input logic [IN_W-1:0] x);
        frame_t f;
        f = '0;
        f[idx] = x;
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     mode;
        mode = $urandom_range(9);
        for (int i = 0; i < N_POINTS; i++)
        begin
            if (mode < 5)
                f[i] = IN_W'($urandom);
            else if (mode < 8)
                case ($urandom_range(4))
                    0: f[i] = 16'h8000;
                    1: f[i] = 16'h7fff;
                    2: f[i] = 16'h0000;
                    3: f[i] = 16'hffff;
                    default: f[i] = IN_W'($urandom);
                endcase
            else
                f[i] = IN_W'($urandom_range(15) - 8);
        end
        return f;
    endfunction

    task automatic add_row(input logic dir, input frame_t f, input logic typed,
                           input spectrum_t want);
        stim_row_t row;
        row.dir   = dir;
        row.frame = f;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [OUT_W-1:0] got, input logic [OUT_W-1:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch at result %0d: %s[%0d] got %0d want %0d", results_seen, what,
                     idx, $signed(got), $signed(want));
        error_count++;
    endtask

    // call right after a rising edge; returns right after the edge that took the word
    task automatic send_frame(input frame_t f, input spectrum_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_q  <= f;
        do
            @(posedge clk);
        while (!in_ready);
        pending_spectra.push_back(want);
        if (model_dir == DIR_FORWARD)
            frames_fwd++;
        else
            frames_bwd++;
    endtask

    task automatic set_direction(input logic dir);
        in_valid <= 1'b0;
        while (pending_spectra.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= dir;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_dir = dir;
    endtask

    task automatic run_phase(input logic dir, input int idle, input int stall, input int count);
        frame_t f;
        set_direction(dir);
        tx_idle_pct  = idle;
        rx_stall_pct = stall;
        repeat (count)
        begin
            f = random_frame();
            send_frame(f, predict_spectrum(f, model_dir));
        end
    endtask

    task automatic run_backpressure(input logic dir, input int count);
        frame_t f;
        set_direction(dir);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (count)
                begin
                    f = random_frame();
                    send_frame(f, predict_spectrum(f, model_dir));
                end
            end
        join
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_spectra.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                input_stalls++;
            if (out_valid && out_ready)
            begin
                got_spectrum = {result_11, result_10, result_9, result_8, result_7, result_6,
                                result_5, result_4, result_3, result_2, result_1, result_0};
                if (pending_spectra.size() == 0)
                begin
                    if (error_count < MAX_PRINTS)
                        $display("unexpected result word after %0d results", results_seen);
                    error_count++;
                end
                else
                begin
                    want_spectrum = pending_spectra.pop_front();
                    for (int i = 0; i < N_POINTS; i++)
                        if (got_spectrum[i] !== want_spectrum[i])
                            report_mismatch("result", i, got_spectrum[i], want_spectrum[i]);
                end
                results_seen++;
            end
        end
        out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        frame_q      = '0;
        rx_hold      = 1'b0;
        model_dir    = DIR_FORWARD;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        frames_fwd   = 0;
        frames_bwd   = 0;

        add_row(DIR_FORWARD, '0, 1'b1, '0);
        add_row(DIR_FORWARD, one_hot(0, 16'd1), 1'b1,
                {24'd1, 24'd0, 24'd1, 24'd0, 24'd1, 24'd0,
                 24'd1, 24'd0, 24'd1, 24'd0, 24'd1, 24'd1});
        add_row(DIR_FORWARD, fill_frame(16'h8000), 1'b1, {{11{24'd0}}, 24'hfa0000});
        add_row(DIR_FORWARD, fill_frame(16'h7fff), 1'b0, '0);
        add_row(DIR_FORWARD, alt_frame(16'h7fff, 16'h8000), 1'b0, '0);
        add_row(DIR_FORWARD, alt_frame(16'h8000, 16'h7fff), 1'b0, '0);
        add_row(DIR_FORWARD, one_hot(1, 16'h8000), 1'b0, '0);
        add_row(DIR_FORWARD, one_hot(5, 16'h7fff), 1'b0, '0);
        add_row(DIR_FORWARD, one_hot(10, 16'h8000), 1'b0, '0);
        add_row(DIR_FORWARD, one_hot(11, 16'hffff), 1'b0, '0);
        add_row(DIR_FORWARD, fill_frame(16'h5555), 1'b0, '0);
        add_row(DIR_FORWARD, fill_frame(16'haaaa), 1'b0, '0);
        add_row(DIR_BACKWARD, '0, 1'b1, '0);
        add_row(DIR_BACKWARD, one_hot(0, 16'd1), 1'b1, {12{24'd1}});
        add_row(DIR_BACKWARD, fill_frame(16'h8000), 1'b0, '0);
        add_row(DIR_BACKWARD, fill_frame(16'h7fff), 1'b0, '0);
        add_row(DIR_BACKWARD, alt_frame(16'h7fff, 16'h8000), 1'b0, '0);
        add_row(DIR_BACKWARD, alt_frame(16'h8000, 16'h7fff), 1'b0, '0);
        add_row(DIR_BACKWARD, one_hot(5, 16'h8000), 1'b0, '0);
        add_row(DIR_BACKWARD, one_hot(6, 16'h7fff), 1'b0, '0);
        add_row(DIR_BACKWARD, one_hot(3, 16'd1), 1'b0, '0);
        add_row(DIR_BACKWARD, one_hot(9, 16'hffff), 1'b0, '0);
        add_row(DIR_BACKWARD, fill_frame(16'h5555), 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_direction(DIR_FORWARD);
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].dir != model_dir)
                set_direction(stim_rows[i].dir);
            send_frame(stim_rows[i].frame, stim_rows[i].typed ? stim_rows[i].want
                       : predict_spectrum(stim_rows[i].frame, stim_rows[i].dir));
        end

        run_phase(DIR_FORWARD, 0, 0, 150);
        run_phase(DIR_FORWARD, 51, 0, 150);
        run_phase(DIR_FORWARD, 0, 51, 150);
        run_phase(DIR_FORWARD, 21, 21, 150);
        run_backpressure(DIR_FORWARD, 40);
        run_phase(DIR_BACKWARD, 0, 0, 150);
        run_phase(DIR_BACKWARD, 51, 0, 150);
        run_phase(DIR_BACKWARD, 0, 51, 150);
        run_phase(DIR_BACKWARD, 21, 21, 150);
        run_backpressure(DIR_BACKWARD, 40);
        run_phase(DIR_FORWARD, 0, 0, 60);

        in_valid <= 1'b0;
        while (pending_spectra.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d forward and %0d inverse frames, %0d result words checked",
                 frames_fwd, frames_bwd, results_seen);
        $display("input held off for %0d cycles under output back-pressure", input_stalls);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
